[hdl/iidl_pkg.sv]
`timescale 1ns / 1ps

package iidl_pkg;

  // list geometry
  localparam int LIST_DEPTH = 128;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
  localparam int PTR_W      = (LEN_W > 8) ? LEN_W : 8;

  // stream word widths
  localparam int DATA_W     = 152;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0]       byte_t;

  // one stored record
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] name;
    logic [7:0]  age;
  } rec_t;

  // request kinds
  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // broadcast control to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic load;
    logic hit;
    logic walk;
    ptr_t pos;
  } cell_ctl_t;

endpackage

[hdl/indexed_insert_delete_list.sv]
`timescale 1ns / 1ps
// a word is taken only when idle; on a read or delete hit the old record walks
//   down the tap chain to cell zero, and every result waits for a free output
//   register before it is loaded and the next word can be taken
// insert and delete shift the cells from the position upward in the accepting cycle
// reset: synchronous active-low rst_n clears length, control and output valid;
//   record cells are not cleared

module indexed_insert_delete_list import iidl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // mode[1:0], position[9:2], record_id[73:10], record_name[137:74],
  // record_age[145:138], zero pad
  input  logic [DATA_W-1:0] in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status[1:0], out_id[65:2], out_name[129:66], out_age[137:130],
  // new_length[145:138], zero pad
  output logic [DATA_W-1:0] out_tdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t    state_r, state_nxt;
  len_t      len_r, len_nxt;
  idx_t      cnt_r, cnt_nxt;
  status_t   st_r, dec_st;
  logic      out_valid_r, out_valid_nxt;
  status_t   out_st_r;
  rec_t      out_rec_r;
  byte_t     out_len_r;

  logic      in_acc, walk, out_load;
  logic      dec_ins, dec_del, dec_hit;
  ptr_t      pos_x, len_x;
  rec_t      in_rec;
  cell_ctl_t ctl;

  rec_t      cell_rec [LIST_DEPTH];
  rec_t      cell_tap [LIST_DEPTH];

  // input word unpack
  assign pos_x       = ptr_t'(in_tdata[9:2]);
  assign len_x       = ptr_t'(len_r);
  assign in_rec.id   = in_tdata[73:10];
  assign in_rec.name = in_tdata[137:74];
  assign in_rec.age  = in_tdata[145:138];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // request decode and bounds checks
  always_comb begin
    dec_st  = ST_OK;
    dec_ins = 1'b0;
    dec_del = 1'b0;
    dec_hit = 1'b0;
    unique case (mode_t'(in_tdata[1:0]))
      MODE_READ, MODE_DELETE: begin
        priority if (len_r == '0) begin
          dec_st = ST_EMPTY;
        end else if (pos_x >= len_x) begin
          dec_st = ST_RANGE;
        end else begin
          dec_hit = 1'b1;
          dec_del = (mode_t'(in_tdata[1:0]) == MODE_DELETE);
        end
      end
      MODE_INSERT: begin
        priority if (len_r == len_t'(LIST_DEPTH)) begin
          dec_st = ST_FULL;
        end else if (pos_x > len_x) begin
          dec_st = ST_RANGE;
        end else begin
          dec_ins = 1'b1;
        end
      end
      default: begin
        dec_st = ST_OK;
      end
    endcase
  end

  // cell control broadcast
  assign walk     = (state_r == S_WALK) && (cnt_r != '0);
  assign out_load = (state_r == S_WALK) && (cnt_r == '0) && (!out_valid_r || out_tready);

  always_comb begin
    ctl.ins  = in_acc && dec_ins;
    ctl.del  = in_acc && dec_del;
    ctl.load = in_acc;
    ctl.hit  = dec_hit;
    ctl.walk = walk;
    ctl.pos  = pos_x;
  end

  // chain of record cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    rec_t left_c, right_c, tap_c;
    if (i == 0) begin : g_first
      assign left_c = in_rec;
    end else begin : g_mid_l
      assign left_c = cell_rec[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_c = '0;
      assign tap_c   = '0;
    end else begin : g_mid_r
      assign right_c = cell_rec[i+1];
      assign tap_c   = cell_tap[i+1];
    end
    iidl_cell u_cell (
      .clk       (clk),
      .idx       (idx_t'(i)),
      .ctl       (ctl),
      .new_rec   (in_rec),
      .left_rec  (left_c),
      .right_rec (right_c),
      .tap_in    (tap_c),
      .rec       (cell_rec[i]),
      .tap       (cell_tap[i])
    );
  end

  // sequencer, length and walk counter
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_WALK;
          cnt_nxt   = dec_hit ? idx_t'(pos_x) : '0;
          if (dec_ins) begin
            len_nxt = len_t'(len_r + 1'b1);
          end else if (dec_del) begin
            len_nxt = len_t'(len_r - 1'b1);
          end
        end
      end
      S_WALK: begin
        if (cnt_r != '0) begin
          cnt_nxt = idx_t'(cnt_r - 1'b1);
        end else if (out_load) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // held status and output word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_r <= dec_st;
    end
    if (out_load) begin
      out_st_r  <= st_r;
      out_rec_r <= cell_tap[0];
      out_len_r <= byte_t'(len_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_len_r, out_rec_r.age, out_rec_r.name, out_rec_r.id, out_st_r};

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= len_t'(LIST_DEPTH))
    else $error("list length above depth");

  a_ins_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec_ins) |=> (len_r == len_t'($past(len_r) + 1'b1)))
    else $error("insert did not grow the list by one");

  a_del_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec_del) |=> (len_r == len_t'($past(len_r) - 1'b1)))
    else $error("delete did not shrink the list by one");

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    walk |=> ((state_r == S_WALK) && (cnt_r == idx_t'($past(cnt_r) - 1'b1))))
    else $error("tap walk counter out of step");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !(out_valid_r && out_tready)) |=> (out_valid_r == $past(out_valid_r)))
    else $error("output valid changed on accept without a drain");
`endif

endmodule

[hdl/iidl_cell.sv]
`timescale 1ns / 1ps

module iidl_cell import iidl_pkg::*; (
  input  logic      clk,
  input  idx_t      idx,
  input  cell_ctl_t ctl,
  input  rec_t      new_rec,
  input  rec_t      left_rec,
  input  rec_t      right_rec,
  input  rec_t      tap_in,
  output rec_t      rec,
  output rec_t      tap
);

  rec_t rec_r, rec_nxt;
  rec_t tap_r, tap_nxt;
  ptr_t idx_x;

  assign idx_x = ptr_t'(idx);

  // record shift: insert pulls from the left, delete from the right
  always_comb begin
    rec_nxt = rec_r;
    priority if (ctl.ins && (idx_x > ctl.pos)) begin
      rec_nxt = left_rec;
    end else if (ctl.ins && (idx_x == ctl.pos)) begin
      rec_nxt = new_rec;
    end else if (ctl.del && (idx_x >= ctl.pos)) begin
      rec_nxt = right_rec;
    end
  end

  // read tap: the hit cell loads its old record, the others clear, taps walk toward cell zero
  always_comb begin
    tap_nxt = tap_r;
    priority if (ctl.load) begin
      tap_nxt = (ctl.hit && (idx_x == ctl.pos)) ? rec_r : '0;
    end else if (ctl.walk) begin
      tap_nxt = tap_in;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    tap_r <= tap_nxt;
  end

  assign rec = rec_r;
  assign tap = tap_r;

endmodule

[sim/indexed_insert_delete_list_tb.sv]
`timescale 1ns / 1ps

module indexed_insert_delete_list_tb;
  import iidl_pkg::*;

  localparam int          CLK_HALF    = 6;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  // one request word as driven on the input stream
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  pos;
    logic [63:0] id;
    logic [63:0] name;
    logic [7:0]  age;
  } list_req_t;

  // one result word as seen on the output stream
  typedef struct {
    logic [1:0]  status;
    logic [63:0] id;
    logic [63:0] name;
    logic [7:0]  age;
    logic [7:0]  len;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // mode, position, record_id, record_name, record_age, zero pad
  logic [DATA_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // status, out_id, out_name, out_age, new_length, zero pad
  logic [DATA_W-1:0] out_tdata;

  // shadow copy of the list contents
  rec_t         shadow_list [LIST_DEPTH];
  int           shadow_len;
  list_result_t pending_results [$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          error_count;
  int          words_sent;
  int          results_checked;
  int          status_seen [4];
  int unsigned cycle_count;

  indexed_insert_delete_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // apply one request to the shadow list and return what the block should answer
  function automatic list_result_t apply_request(input list_req_t r);
    list_result_t res;
    int           i;
    res = '{default: '0};
    case (r.mode)
      MODE_READ, MODE_DELETE: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (r.pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.status = ST_OK;
          res.id     = shadow_list[r.pos].id;
          res.name   = shadow_list[r.pos].name;
          res.age    = shadow_list[r.pos].age;
          if (r.mode == MODE_DELETE) begin
            for (i = r.pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
            shadow_len--;
          end
        end
      end
      MODE_INSERT: begin
        if (shadow_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (r.pos > shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.status = ST_OK;
          for (i = shadow_len; i > r.pos; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[r.pos] = '{id: r.id, name: r.name, age: r.age};
          shadow_len++;
        end
      end
      default: res.status = ST_OK;
    endcase
    res.len = shadow_len[7:0];
    return res;
  endfunction

  function automatic list_req_t make_req(input logic [1:0] mode, input logic [7:0] pos,
                                         input logic [63:0] id, input logic [63:0] name,
                                         input logic [7:0] age);
    list_req_t r;
    r = '{mode: mode, pos: pos, id: id, name: name, age: age};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // request with random record content
  function automatic list_req_t rand_content_req(input logic [1:0] mode, input int pos);
    return make_req(mode, pos[7:0], rand64(), rand64(), 8'($urandom_range(255)));
  endfunction

  // drive one word, return right after the accepting edge with valid still high
  task automatic send_word(input list_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, r.age, r.name, r.id, r.pos, r.mode};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(r));
    words_sent++;
  endtask

  task automatic sender_rest();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // stop sending until every expected result has come back
  task automatic wait_drain();
    sender_rest();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, exp_v, act_v);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %0h", out_tdata);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", exp_r.status, out_tdata[1:0]);
        check_field("out_id", exp_r.id, out_tdata[65:2]);
        check_field("out_name", exp_r.name, out_tdata[129:66]);
        check_field("out_age", exp_r.age, out_tdata[137:130]);
        check_field("new_length", exp_r.len, out_tdata[145:138]);
        status_seen[exp_r.status]++;
        results_checked++;
      end
    end
  end

  // receiver ready, with random stalls and long hold-offs
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // empty list, bounds, ends, middle and unused mode
  task automatic test_directed();
    send_word(make_req(MODE_READ, 8'd0, '0, '0, '0));
    send_word(make_req(MODE_DELETE, 8'd0, '0, '0, '0));
    send_word(make_req(MODE_DELETE, 8'd255, '1, '1, '1));
    send_word(make_req(MODE_UNUSED, 8'd0, '1, '1, '1));
    send_word(make_req(MODE_INSERT, 8'd1, rand64(), rand64(), 8'd7));
    send_word(make_req(MODE_INSERT, 8'd255, '1, '1, '1));
    send_word(make_req(MODE_INSERT, 8'd0, '1, '1, 8'hff));
    send_word(make_req(MODE_INSERT, 8'd1, '0, '0, 8'h00));
    send_word(make_req(MODE_INSERT, 8'd0, {16{4'h5}}, {16{4'h5}}, 8'h55));
    send_word(make_req(MODE_INSERT, 8'd1, {16{4'ha}}, {16{4'ha}}, 8'haa));
    send_word(make_req(MODE_READ, 8'd0, '0, '0, '0));
    send_word(make_req(MODE_READ, 8'd3, '0, '0, '0));
    send_word(make_req(MODE_READ, 8'd4, '0, '0, '0));
    send_word(make_req(MODE_READ, 8'd255, '0, '0, '0));
    send_word(make_req(MODE_UNUSED, 8'd2, rand64(), rand64(), 8'h3c));
    send_word(make_req(MODE_DELETE, 8'd1, '0, '0, '0));
    send_word(make_req(MODE_DELETE, 8'd2, '0, '0, '0));
    send_word(make_req(MODE_DELETE, 8'd3, '0, '0, '0));
    send_word(make_req(MODE_DELETE, 8'd0, '0, '0, '0));
    send_word(make_req(MODE_READ, 8'd0, '0, '0, '0));
    send_word(make_req(MODE_DELETE, 8'd0, '0, '0, '0));
    send_word(make_req(MODE_READ, 8'd0, '0, '0, '0));
    wait_drain();
  endtask

  // grow the list to full, hit the full case, then empty it again
  task automatic test_fill_and_drain();
    while (shadow_len < LIST_DEPTH) begin
      if ($urandom_range(99) < 15)
        send_word(rand_content_req(MODE_READ, $urandom_range(shadow_len - 1)));
      else
        send_word(rand_content_req(MODE_INSERT, $urandom_range(shadow_len)));
    end
    // full takes priority over a bad position
    send_word(rand_content_req(MODE_INSERT, 0));
    send_word(rand_content_req(MODE_INSERT, LIST_DEPTH));
    send_word(rand_content_req(MODE_INSERT, 255));
    send_word(rand_content_req(MODE_READ, LIST_DEPTH - 1));
    send_word(rand_content_req(MODE_READ, LIST_DEPTH));
    send_word(rand_content_req(MODE_DELETE, LIST_DEPTH - 1));
    send_word(rand_content_req(MODE_INSERT, LIST_DEPTH - 1));
    while (shadow_len > 0) begin
      if ($urandom_range(99) < 10)
        send_word(rand_content_req(MODE_READ, $urandom_range(shadow_len - 1)));
      else
        send_word(rand_content_req(MODE_DELETE, $urandom_range(shadow_len - 1)));
    end
    send_word(rand_content_req(MODE_DELETE, 0));
    wait_drain();
  endtask

  // random mix: mostly well-formed requests, some noise and unused mode
  task automatic test_random_mix(input int count);
    int roll;
    int ins_pct;
    repeat (count) begin
      roll    = $urandom_range(99);
      ins_pct = (shadow_len < 16) ? 60 : ((shadow_len > 110) ? 25 : 40);
      if (roll < 4) begin
        send_word(make_req(MODE_UNUSED, 8'($urandom_range(255)), rand64(), rand64(),
                           8'($urandom_range(255))));
      end else if (roll < 12) begin
        send_word(rand_content_req(2'($urandom_range(2)), $urandom_range(255)));
      end else if ($urandom_range(99) < ins_pct) begin
        send_word(rand_content_req(MODE_INSERT, $urandom_range(shadow_len)));
      end else if (shadow_len == 0) begin
        send_word(rand_content_req($urandom_range(1) ? MODE_READ : MODE_DELETE, 0));
      end else if ($urandom_range(1)) begin
        send_word(rand_content_req(MODE_READ, $urandom_range(shadow_len - 1)));
      end else begin
        send_word(rand_content_req(MODE_DELETE, $urandom_range(shadow_len - 1)));
      end
    end
    wait_drain();
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 400;
    for (i = 0; i < 24; i++) begin
      if (shadow_len > 0 && i[0])
        send_word(rand_content_req(MODE_READ, $urandom_range(shadow_len - 1)));
      else
        send_word(rand_content_req(MODE_INSERT, $urandom_range(shadow_len)));
    end
    wait_drain();
  endtask

  // main sequence
  initial begin
    int phase;
    error_count     = 0;
    words_sent      = 0;
    results_checked = 0;
    hold_left       = 0;
    shadow_len      = 0;
    cycle_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    status_seen     = '{default: 0};
    foreach (shadow_list[i]) shadow_list[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      test_random_mix(360);
    end
    test_backpressure();

    wait_drain();
    repeat (LIST_DEPTH + 16) @(posedge clk);

    $display("requests sent %0d, results checked %0d, over four idle/stall mixes",
             words_sent, results_checked);
    $display("status counts: ok %0d, range %0d, full %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/iidl_pkg.sv
hdl/iidl_cell.sv
hdl/indexed_insert_delete_list.sv
sim/indexed_insert_delete_list_tb.sv
